// File: src/sci_pkg.sv
// ----------------------------------------------------------------------------
// sci_pkg
// Shared constants, codes and widths for the stick-to-cursor integrator.
// ----------------------------------------------------------------------------
package sci_pkg;

    // Fraction bits of the cursor position (unsigned Q12.FRAC)
    localparam int SCI_FRAC   = 16;
    localparam int SCI_INT_W  = 12;
    localparam int SCI_POS_W  = SCI_INT_W + SCI_FRAC;

    // Field widths
    localparam int SCI_SIZE_W = 13;
    localparam int SCI_GAIN_W = 32;
    localparam int SCI_STK_W  = 16;
    localparam int SCI_MS_W   = 16;
    localparam int SCI_NUM_W  = 8;

    // Largest window size in pixels
    localparam logic [SCI_SIZE_W-1:0] SCI_SIZE_MAX = SCI_SIZE_W'(4096);

    // Gain times elapsed product, and its split for the magnitude multiply
    localparam int SCI_GM_W   = SCI_GAIN_W + SCI_MS_W;
    localparam int SCI_SH     = 32 - SCI_FRAC;
    localparam int SCI_HI_W   = SCI_GM_W - SCI_SH;
    localparam int SCI_MA_W   = (SCI_HI_W > SCI_GAIN_W) ? SCI_HI_W : SCI_GAIN_W;
    localparam int SCI_MB_W   = 16;
    localparam int SCI_PROD_W = SCI_MA_W + SCI_MB_W;
    localparam int SCI_ACC_W  = SCI_HI_W + SCI_STK_W + 1;

    // Input action codes
    localparam logic [1:0] SCI_ACT_AXIS   = 2'd0;
    localparam logic [1:0] SCI_ACT_BUTTON = 2'd1;
    localparam logic [1:0] SCI_ACT_TICK   = 2'd2;

    // Result kinds
    localparam logic [1:0] SCI_RES_MOTION = 2'd0;
    localparam logic [1:0] SCI_RES_DOWN   = 2'd1;
    localparam logic [1:0] SCI_RES_UP     = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] SCI_REG_WIDTH  = 2'd0;
    localparam logic [1:0] SCI_REG_HEIGHT = 2'd1;
    localparam logic [1:0] SCI_REG_GAIN   = 2'd2;

endpackage

// File: src/sci_mul.sv
// ----------------------------------------------------------------------------
// sci_mul
// Shared unsigned multiplier used for every product of a tick.
// ----------------------------------------------------------------------------
module sci_mul (
    input  logic [sci_pkg::SCI_MA_W-1:0]   i_a,
    input  logic [sci_pkg::SCI_MB_W-1:0]   i_b,
    output logic [sci_pkg::SCI_PROD_W-1:0] o_prod
);
    import sci_pkg::*;

    // Form the full-width product
    assign o_prod = SCI_PROD_W'(i_a) * SCI_PROD_W'(i_b);

endmodule

// File: src/sci_axis_upd.sv
// ----------------------------------------------------------------------------
// sci_axis_upd
// Moves one cursor coordinate by a delta and clamps it to the window.
// ----------------------------------------------------------------------------
module sci_axis_upd (
    input  logic [sci_pkg::SCI_POS_W-1:0]  i_pos,
    input  logic [sci_pkg::SCI_ACC_W-1:0]  i_delta,
    input  logic                           i_dec,
    input  logic [sci_pkg::SCI_SIZE_W-1:0] i_size,
    output logic [sci_pkg::SCI_POS_W-1:0]  o_pos
);
    import sci_pkg::*;

    logic [SCI_SIZE_W-1:0] w_size;
    logic [SCI_SIZE_W-1:0] w_size_m1;
    logic [SCI_POS_W:0]    w_limit;
    logic [SCI_POS_W:0]    w_delta;
    logic [SCI_POS_W:0]    w_pos;
    logic [SCI_POS_W:0]    w_sum;

    // Effective size: zero counts as one, large values saturate
    always_comb begin
        if (i_size == '0) begin
            w_size = SCI_SIZE_W'(1);
        end else if (i_size > SCI_SIZE_MAX) begin
            w_size = SCI_SIZE_MAX;
        end else begin
            w_size = i_size;
        end
    end

    assign w_size_m1 = w_size - SCI_SIZE_W'(1);
    assign w_limit   = (SCI_POS_W+1)'({w_size, {SCI_FRAC{1'b0}}});
    assign w_pos     = {1'b0, i_pos};

    // Saturate the delta just above the position range
    always_comb begin
        if (|i_delta[SCI_ACC_W-1:SCI_POS_W]) begin
            w_delta = {1'b1, {SCI_POS_W{1'b0}}};
        end else begin
            w_delta = {1'b0, i_delta[SCI_POS_W-1:0]};
        end
    end

    // Step towards zero or away from it, then clamp to the far edge
    always_comb begin
        if (i_dec) begin
            w_sum = (w_delta > w_pos) ? '0 : w_pos - w_delta;
        end else begin
            w_sum = w_pos + w_delta;
        end
        if (w_sum >= w_limit) begin
            o_pos = {w_size_m1[SCI_INT_W-1:0], {SCI_FRAC{1'b0}}};
        end else begin
            o_pos = w_sum[SCI_POS_W-1:0];
        end
    end

endmodule

// File: src/stick_to_cursor_integrator_core.sv
// ----------------------------------------------------------------------------
// stick_to_cursor_integrator_core
// Integrates analog stick deflection over time ticks into a cursor position.
// ----------------------------------------------------------------------------
// Axis items, and button items for buttons other than button 0, are taken
// back to back; a button-0 item goes from its transfer to S_EMIT, which
// loads the output register. A tick steps through S_GM, then S_LO, S_HI
// and S_UPD for x and again for y, then S_CMP, and S_EMIT when it reports
// motion: one 32x16 multiplier is shared by the sequencer, which forms gain
// times elapsed once and then the low and high partial products with each
// stick magnitude, updates x and then y, and compares the new integer
// position with the last one reported. An item that gives a result holds
// the sequencer until the output register is free to take it.
// ----------------------------------------------------------------------------
module stick_to_cursor_integrator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] event_number, [23:8] event_value,
                                        // [39:24] elapsed_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [11:0] cursor_x, [23:12] cursor_y
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import sci_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_GM   = 3'd1;
    localparam logic [2:0] S_LO   = 3'd2;
    localparam logic [2:0] S_HI   = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_CMP  = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [SCI_SIZE_W-1:0] r_width, r_height;
    logic [SCI_GAIN_W-1:0] r_gain;
    logic [SCI_STK_W-1:0]  r_stick_x, r_stick_y;
    logic [SCI_POS_W-1:0]  r_pos_x, r_pos_y;
    logic [SCI_INT_W-1:0]  r_last_x, r_last_y;
    logic                  r_reported;
    logic                  r_axis;
    logic [SCI_MS_W-1:0]   r_ms;
    logic [SCI_GM_W-1:0]   r_gm;
    logic [SCI_ACC_W-1:0]  r_acc;
    logic [1:0]            r_pend_kind;
    logic [SCI_INT_W-1:0]  r_pend_x, r_pend_y;
    logic                  r_m_valid;
    logic [1:0]            r_m_kind;
    logic [SCI_INT_W-1:0]  r_m_x, r_m_y;

    logic [1:0]            w_action;
    logic [SCI_NUM_W-1:0]  w_num;
    logic [SCI_STK_W-1:0]  w_val;
    logic [SCI_MS_W-1:0]   w_ms;
    logic                  w_in_xfer;
    logic                  w_out_free;
    logic [SCI_STK_W-1:0]  w_stick;
    logic [SCI_STK_W-1:0]  w_mag;
    logic                  w_dec;
    logic [SCI_MA_W-1:0]   w_mul_a;
    logic [SCI_MB_W-1:0]   w_mul_b;
    logic [SCI_PROD_W-1:0] w_prod;
    logic [SCI_POS_W-1:0]  w_upd_pos;
    logic [SCI_POS_W-1:0]  w_new_pos;
    logic [SCI_SIZE_W-1:0] w_size;
    logic [SCI_INT_W-1:0]  w_ix, w_iy;

    // Unpack the input transfer
    assign w_action   = s_axis_tuser;
    assign w_num      = s_axis_tdata[7:0];
    assign w_val      = s_axis_tdata[23:8];
    assign w_ms       = s_axis_tdata[39:24];
    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_xfer  = s_axis_tvalid && s_axis_tready;
    assign w_out_free = !r_m_valid || m_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Select the axis being worked on
    assign w_stick   = r_axis ? r_stick_y : r_stick_x;
    assign w_upd_pos = r_axis ? r_pos_y : r_pos_x;
    assign w_size    = r_axis ? r_height : r_width;
    assign w_mag     = w_stick[SCI_STK_W-1] ? (~w_stick + SCI_STK_W'(1)) : w_stick;
    assign w_dec     = !w_stick[SCI_STK_W-1] && (w_stick != '0);

    // Route operands into the shared multiplier
    always_comb begin
        case (r_state)
            S_GM: begin
                w_mul_a = SCI_MA_W'(r_gain);
                w_mul_b = SCI_MB_W'(r_ms);
            end
            S_LO: begin
                w_mul_a = SCI_MA_W'(r_gm[SCI_SH-1:0]);
                w_mul_b = SCI_MB_W'(w_mag);
            end
            S_HI: begin
                w_mul_a = SCI_MA_W'(r_gm[SCI_GM_W-1:SCI_SH]);
                w_mul_b = SCI_MB_W'(w_mag);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    sci_mul u_mul (
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    sci_axis_upd u_upd (
        .i_pos   (w_upd_pos),
        .i_delta (r_acc),
        .i_dec   (w_dec),
        .i_size  (w_size),
        .o_pos   (w_new_pos)
    );

    assign w_ix = r_pos_x[SCI_POS_W-1:SCI_FRAC];
    assign w_iy = r_pos_y[SCI_POS_W-1:SCI_FRAC];

    // Sequence the tick and hand results to the output stage
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    if (w_action == SCI_ACT_TICK) begin
                        n_state = S_GM;
                    end else if (w_action == SCI_ACT_BUTTON && w_num == '0) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_GM:  n_state = S_LO;
            S_LO:  n_state = S_HI;
            S_HI:  n_state = S_UPD;
            S_UPD: n_state = r_axis ? S_CMP : S_LO;
            S_CMP: begin
                if (!r_reported || w_ix != r_last_x || w_iy != r_last_y) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_width    <= SCI_SIZE_W'(640);
            r_height   <= SCI_SIZE_W'(480);
            r_gain     <= SCI_GAIN_W'(41945);
            r_stick_x  <= '0;
            r_stick_y  <= '0;
            r_pos_x    <= '0;
            r_pos_y    <= '0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_reported <= 1'b0;
            r_axis     <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // Take configuration writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    SCI_REG_WIDTH:  r_width  <= i_cfg_data[SCI_SIZE_W-1:0];
                    SCI_REG_HEIGHT: r_height <= i_cfg_data[SCI_SIZE_W-1:0];
                    SCI_REG_GAIN:   r_gain   <= i_cfg_data;
                    default: ;
                endcase
            end

            // Store stick deflection
            if (w_in_xfer && w_action == SCI_ACT_AXIS) begin
                if (w_num == SCI_NUM_W'(0)) begin
                    r_stick_x <= w_val;
                end else if (w_num == SCI_NUM_W'(1)) begin
                    r_stick_y <= w_val;
                end
            end

            // Start on x for every tick
            if (r_state == S_GM) begin
                r_axis <= 1'b0;
            end

            // Write back the updated coordinate and advance the axis
            if (r_state == S_UPD) begin
                if (r_axis) begin
                    r_pos_y <= w_new_pos;
                end else begin
                    r_pos_x <= w_new_pos;
                end
                r_axis <= !r_axis;
            end

            // Record the reported position
            if (r_state == S_CMP && n_state == S_EMIT) begin
                r_last_x   <= w_ix;
                r_last_y   <= w_iy;
                r_reported <= 1'b1;
            end

            // Output register
            if (r_state == S_EMIT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_ms <= w_ms;
        end
        if (r_state == S_GM) begin
            r_gm <= w_prod[SCI_GM_W-1:0];
        end
        if (r_state == S_LO) begin
            r_acc <= SCI_ACC_W'(w_prod >> SCI_SH);
        end else if (r_state == S_HI) begin
            r_acc <= r_acc + SCI_ACC_W'(w_prod);
        end

        // Hold the pending result
        if (w_in_xfer && w_action == SCI_ACT_BUTTON) begin
            r_pend_kind <= (w_val != '0) ? SCI_RES_DOWN : SCI_RES_UP;
            r_pend_x    <= r_last_x;
            r_pend_y    <= r_last_y;
        end else if (r_state == S_CMP) begin
            r_pend_kind <= SCI_RES_MOTION;
            r_pend_x    <= w_ix;
            r_pend_y    <= w_iy;
        end

        if (r_state == S_EMIT && w_out_free) begin
            r_m_kind <= r_pend_kind;
            r_m_x    <= r_pend_x;
            r_m_y    <= r_pend_y;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_kind;
    assign m_axis_tdata  = {r_m_y, r_m_x};

endmodule
